// ----- sv/sha1_pkg.sv -----
package sha1_pkg;

	localparam int unsigned WORDS = 5;
	localparam int unsigned WIN_WORDS = 16;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [2:0] LAST_WORD = 3'd4;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] INIT_WORDS [WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [31:0] ROUND_K [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	typedef struct packed {
		logic shift_byte;
		logic step;
	} sched_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

endpackage

// ----- sv/sha1_hash_engine.sv -----
// channel  | handshake                   | payload
// msg      | msg_valid / msg_ready       | operation, data_byte
// digest   | digest_valid / digest_ready | digest_word, word_index, last_word
//
// the byte that fills a block starts its 80 rounds through the one shared
// round unit, then the chaining add
// a finish pads out the block and hashes it, then pads and hashes a second block
// when fill >= 56, then hands out the five digest words
// msg_ready is high only while idle; a stalled digest word holds until taken
// reset restores the initial chaining value and clears the counters
module sha1_hash_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   msg_valid,
	output logic                   msg_ready,
	input  sha1_pkg::msg_item_t    msg,
	output logic                   digest_valid,
	input  logic                   digest_ready,
	output sha1_pkg::digest_item_t digest
);

	sha1_pkg::state_t     state_q, state_d;
	sha1_pkg::sched_ctl_t sched_ctl;
	sha1_pkg::work_t      work_q, work_next, chain_work;

	logic [31:0] chain_q [sha1_pkg::WORDS];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [6:0]  round_q;
	logic [5:0]  pos_q;
	logic        first_q;
	logic        len_blk_q;
	logic        pad_q;
	logic [2:0]  word_idx_q;
	logic [7:0]  pad_byte;
	logic [7:0]  sched_byte;
	logic [31:0] w;
	logic        msg_acc;
	logic        dig_acc;

	assign msg_acc = msg_valid && msg_ready;
	assign dig_acc = digest_valid && digest_ready;

	assign chain_work = '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3],
		e: chain_q[4]};

	// padding stream: marker, zeros, then the length big-endian in the last 8 bytes
	always_comb begin
		if (first_q) begin
			pad_byte = sha1_pkg::PAD_BYTE;
		end else if (len_blk_q && pos_q >= sha1_pkg::LEN_POS) begin
			pad_byte = bits_q[{~pos_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign sched_byte = (state_q == sha1_pkg::ST_PAD) ? pad_byte : msg.data_byte;

	sha1_sched u_sched (
		.clk     (clk),
		.ctl     (sched_ctl),
		.byte_in (sched_byte),
		.w       (w)
	);

	sha1_round u_round (
		.work      (work_q),
		.w         (w),
		.round     (round_q),
		.work_next (work_next)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (msg_acc) begin
					if (msg.operation == sha1_pkg::OP_FINISH) begin
						state_d = sha1_pkg::ST_PAD;
					end else if (fill_q == sha1_pkg::LAST_POS) begin
						state_d = sha1_pkg::ST_ROUND;
					end
				end
			end
			sha1_pkg::ST_PAD: begin
				if (pos_q == sha1_pkg::LAST_POS) begin
					state_d = sha1_pkg::ST_ROUND;
				end
			end
			sha1_pkg::ST_ROUND: begin
				if (round_q == sha1_pkg::LAST_ROUND) begin
					state_d = sha1_pkg::ST_FOLD;
				end
			end
			sha1_pkg::ST_FOLD: begin
				if (!pad_q) begin
					state_d = sha1_pkg::ST_IDLE;
				end else if (len_blk_q) begin
					state_d = sha1_pkg::ST_EMIT;
				end else begin
					state_d = sha1_pkg::ST_PAD;
				end
			end
			sha1_pkg::ST_EMIT: begin
				if (dig_acc && word_idx_q == sha1_pkg::LAST_WORD) begin
					state_d = sha1_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		msg_ready = 1'b0;
		digest_valid = 1'b0;
		sched_ctl = '0;
		case (state_q)
			sha1_pkg::ST_IDLE: begin
				msg_ready = 1'b1;
				sched_ctl.shift_byte = msg_valid && (msg.operation == sha1_pkg::OP_ABSORB);
			end
			sha1_pkg::ST_PAD: begin
				sched_ctl.shift_byte = 1'b1;
			end
			sha1_pkg::ST_ROUND: begin
				sched_ctl.step = 1'b1;
			end
			sha1_pkg::ST_EMIT: begin
				digest_valid = 1'b1;
			end
			default: begin
				msg_ready = 1'b0;
			end
		endcase
	end

	assign digest.digest_word = chain_q[word_idx_q];
	assign digest.word_index = word_idx_q;
	assign digest.last_word = (word_idx_q == sha1_pkg::LAST_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1_pkg::ST_IDLE;
			for (int i = 0; i < sha1_pkg::WORDS; i++) begin
				chain_q[i] <= sha1_pkg::INIT_WORDS[i];
			end
			fill_q <= '0;
			bits_q <= '0;
			round_q <= '0;
			pos_q <= '0;
			first_q <= 1'b0;
			len_blk_q <= 1'b0;
			pad_q <= 1'b0;
			word_idx_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sha1_pkg::ST_IDLE: begin
					round_q <= '0;
					if (msg_acc) begin
						if (msg.operation == sha1_pkg::OP_ABSORB) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
							pad_q <= 1'b0;
						end else begin
							pos_q <= fill_q;
							first_q <= 1'b1;
							len_blk_q <= (fill_q < sha1_pkg::LEN_POS);
							pad_q <= 1'b1;
						end
					end
				end
				sha1_pkg::ST_PAD: begin
					pos_q <= pos_q + 6'd1;
					first_q <= 1'b0;
					round_q <= '0;
				end
				sha1_pkg::ST_ROUND: begin
					round_q <= round_q + 7'd1;
				end
				sha1_pkg::ST_FOLD: begin
					chain_q[0] <= chain_q[0] + work_q.a;
					chain_q[1] <= chain_q[1] + work_q.b;
					chain_q[2] <= chain_q[2] + work_q.c;
					chain_q[3] <= chain_q[3] + work_q.d;
					chain_q[4] <= chain_q[4] + work_q.e;
					word_idx_q <= '0;
					// second padding block carries only zeros and the length
					if (pad_q && !len_blk_q) begin
						pos_q <= '0;
						len_blk_q <= 1'b1;
					end
				end
				sha1_pkg::ST_EMIT: begin
					if (dig_acc) begin
						word_idx_q <= word_idx_q + 3'd1;
						if (word_idx_q == sha1_pkg::LAST_WORD) begin
							for (int i = 0; i < sha1_pkg::WORDS; i++) begin
								chain_q[i] <= sha1_pkg::INIT_WORDS[i];
							end
							fill_q <= '0;
							bits_q <= '0;
							pad_q <= 1'b0;
						end
					end
				end
				default: begin
					round_q <= '0;
				end
			endcase
		end
	end

	// working variables load from the chaining value as a block starts
	always_ff @(posedge clk) begin
		if (state_q == sha1_pkg::ST_ROUND) begin
			work_q <= work_next;
		end else if (state_d == sha1_pkg::ST_ROUND) begin
			work_q <= chain_work;
		end
	end

`ifndef SYNTHESIS
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && digest_valid))
		else $error("msg_ready and digest_valid high together");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1_pkg::ST_ROUND) |-> (round_q <= sha1_pkg::LAST_ROUND))
		else $error("round counter out of range");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (digest.word_index <= sha1_pkg::LAST_WORD))
		else $error("digest word index out of range");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && digest.last_word) |=> (msg_ready && fill_q == 6'd0 && bits_q == 64'd0))
		else $error("engine not restored after last digest word");

	a_pad_start: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_acc && msg.operation == sha1_pkg::OP_FINISH) |=> (first_q && pad_q))
		else $error("finish request did not start padding");
`endif

endmodule

// ----- sv/sha1_round.sv -----
module sha1_round (
	input  sha1_pkg::work_t  work,
	input  logic [31:0]      w,
	input  logic [6:0]       round,
	output sha1_pkg::work_t  work_next
);

	logic [1:0]  phase;
	logic [31:0] f;
	logic [31:0] t;

	always_comb begin
		if (round < 7'd20) begin
			phase = 2'd0;
		end else if (round < 7'd40) begin
			phase = 2'd1;
		end else if (round < 7'd60) begin
			phase = 2'd2;
		end else begin
			phase = 2'd3;
		end
	end

	always_comb begin
		case (phase)
			2'd0: begin
				f = (work.b & work.c) | (~work.b & work.d);
			end
			2'd2: begin
				f = (work.b & work.c) | (work.b & work.d) | (work.c & work.d);
			end
			default: begin
				f = work.b ^ work.c ^ work.d;
			end
		endcase
	end

	assign t = {work.a[26:0], work.a[31:27]} + f + work.e + sha1_pkg::ROUND_K[phase] + w;

	always_comb begin
		work_next.a = t;
		work_next.b = work.a;
		work_next.c = {work.b[1:0], work.b[31:2]};
		work_next.d = work.c;
		work_next.e = work.d;
	end

endmodule

// ----- sv/sha1_sched.sv -----
module sha1_sched (
	input  logic                 clk,
	input  sha1_pkg::sched_ctl_t ctl,
	input  logic [7:0]           byte_in,
	output logic [31:0]          w
);

	// 16-word window, word 0 is the oldest: bytes enter at the low byte of word 15,
	// rounds pull word 0 out and push the next schedule word
	logic [31:0] win_q [sha1_pkg::WIN_WORDS];
	logic [31:0] mix;

	assign mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign w = win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.shift_byte) begin
			for (int i = 0; i < sha1_pkg::WIN_WORDS - 1; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i + 1][31:24]};
			end
			win_q[sha1_pkg::WIN_WORDS - 1] <= {win_q[sha1_pkg::WIN_WORDS - 1][23:0], byte_in};
		end else if (ctl.step) begin
			for (int i = 0; i < sha1_pkg::WIN_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[sha1_pkg::WIN_WORDS - 1] <= {mix[30:0], mix[31]};
		end
	end

endmodule
